### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// checked on every rising edge
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    localparam int TLB_ENTRIES = 16;
    localparam int PAGE_BITS   = 8;
    localparam int OFFSET_BITS = 8;

    localparam int ADDR_W      = 16;
    localparam int FRAME_W     = 8;
    localparam int NEXT_W      = 9;
    localparam int COUNT_W     = 16;
    localparam int NUM_PAGES   = 1 << PAGE_BITS;
    localparam int TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int VA_W        = PAGE_BITS + OFFSET_BITS;

    typedef enum logic [1:0] {
        OUT_TLB_HIT = 2'd0,
        OUT_PT_HIT  = 2'd1,
        OUT_FAULT   = 2'd2
    } t_outcome;

    typedef struct packed {
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

### rtl/tlbpt_ram.sv
// ----------------------------------------------------------------------------
// tlbpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tlbpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer: takes an address, then commits the lookup once the output
// register is free.
// ----------------------------------------------------------------------------
module tlbpt_ctrl
    import tlbpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOOK;
                end
            end
            S_LOOK: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### rtl/tlbpt_dp.sv
// ----------------------------------------------------------------------------
// tlbpt_dp
// TLB, page table, frame allocator, counters and result register.
// ----------------------------------------------------------------------------
module tlbpt_dp
    import tlbpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [ADDR_W-1:0]  i_virtual_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FRAME_W-1:0] o_frame,
    output logic [ADDR_W-1:0]  o_physical_address,
    output logic [1:0]         o_outcome,
    output logic [COUNT_W-1:0] o_tlb_hit_count,
    output logic [COUNT_W-1:0] o_fault_count
);

    logic [VA_W-1:0]        va_ext;
    logic [PAGE_BITS-1:0]   r_page;
    logic [OFFSET_BITS-1:0] r_offset;

    logic [PAGE_BITS-1:0]   r_tlb_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid;
    logic [TLB_IDX_W-1:0]   r_oldest;

    logic [NUM_PAGES-1:0]   r_page_valid;
    logic [NEXT_W-1:0]      r_next_frame;
    logic [COUNT_W-1:0]     r_hits;
    logic [COUNT_W-1:0]     r_faults;

    logic                   r_out_valid;
    logic [FRAME_W-1:0]     r_frame;
    logic [ADDR_W-1:0]      r_paddr;
    t_outcome               r_outcome;

    logic                   tlb_hit;
    logic [FRAME_W-1:0]     tlb_frame;
    logic [FRAME_W-1:0]     pt_frame;
    logic                   fault;
    t_outcome               outcome;
    logic [FRAME_W-1:0]     frame;
    logic [FRAME_W+OFFSET_BITS-1:0] paddr_full;

    assign va_ext = VA_W'(i_virtual_address);

    tlbpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_PAGES)
    ) u_page_frame (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && fault),
        .i_waddr (r_page),
        .i_wdata (r_next_frame[FRAME_W-1:0]),
        .i_re    (i_cmd.accept),
        .i_raddr (va_ext[OFFSET_BITS +: PAGE_BITS]),
        .o_rdata (pt_frame)
    );

    // lowest matching slot wins
    always_comb begin
        tlb_hit   = 1'b0;
        tlb_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_tlb_valid[i] && (r_tlb_page[i] == r_page)) begin
                tlb_hit   = 1'b1;
                tlb_frame = r_tlb_frame[i];
            end
        end
    end

    always_comb begin
        fault = 1'b0;
        if (tlb_hit) begin
            outcome = OUT_TLB_HIT;
            frame   = tlb_frame;
        end else if (r_page_valid[r_page]) begin
            outcome = OUT_PT_HIT;
            frame   = pt_frame;
        end else begin
            outcome = OUT_FAULT;
            frame   = r_next_frame[FRAME_W-1:0];
            fault   = 1'b1;
        end
    end

    assign paddr_full = {frame, r_offset};
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page   <= va_ext[OFFSET_BITS +: PAGE_BITS];
            r_offset <= va_ext[OFFSET_BITS-1:0];
        end
        if (i_cmd.commit) begin
            r_frame   <= frame;
            r_paddr   <= ADDR_W'(paddr_full);
            r_outcome <= outcome;
            if (!tlb_hit) begin
                r_tlb_page[r_oldest]  <= r_page;
                r_tlb_frame[r_oldest] <= frame;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlb_valid  <= '0;
            r_oldest     <= '0;
            r_page_valid <= '0;
            r_next_frame <= '0;
            r_hits       <= '0;
            r_faults     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (tlb_hit) begin
                    if (r_hits != '1) begin
                        r_hits <= r_hits + 1'b1;
                    end
                end else begin
                    r_tlb_valid[r_oldest] <= 1'b1;
                    if (r_oldest == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
                        r_oldest <= '0;
                    end else begin
                        r_oldest <= r_oldest + 1'b1;
                    end
                end
                if (fault) begin
                    r_page_valid[r_page] <= 1'b1;
                    r_next_frame         <= r_next_frame + 1'b1;
                    if (r_faults != '1) begin
                        r_faults <= r_faults + 1'b1;
                    end
                end
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frame            = r_frame;
    assign o_physical_address = r_paddr;
    assign o_outcome          = r_outcome;
    assign o_tlb_hit_count    = r_hits;
    assign o_fault_count      = r_faults;

endmodule

### rtl/tlb_page_table_translate.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translate
// Virtual to physical translation through a FIFO-replaced TLB backed by a
// demand-paged page table.
// ----------------------------------------------------------------------------
// One address is in flight at a time. The transfer cycle reads the page table
// RAM; the lookup then compares all TLB entries, picks the frame, writes back
// the page table (on a fault) and the TLB (on a miss) and loads the result
// register. A result waiting on a stalled output does not block the next
// input transfer, but the lookup of that next address waits until the result
// register is free. Page-valid bits reset at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlb_page_table_translate
    import tlbpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [ADDR_W-1:0]  i_virtual_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FRAME_W-1:0] o_frame,
    output logic [ADDR_W-1:0]  o_physical_address,
    output logic [1:0]         o_outcome,
    output logic [COUNT_W-1:0] o_tlb_hit_count,
    output logic [COUNT_W-1:0] o_fault_count
);

    t_cmd cmd;
    t_sts sts;

    tlbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tlbpt_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_virtual_address  (i_virtual_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame            (o_frame),
        .o_physical_address (o_physical_address),
        .o_outcome          (o_outcome),
        .o_tlb_hit_count    (o_tlb_hit_count),
        .o_fault_count      (o_fault_count)
    );

    `ASSERT_ALWAYS(a_no_accept_commit, !(cmd.accept && cmd.commit), "accept during commit")
    `ASSERT_RST(a_commit_shows, cmd.commit |=> o_out_valid, "commit lost result")
    `ASSERT_RST(a_result_src, $rose(o_out_valid) |-> $past(cmd.commit), "result without commit")
    `ASSERT_RST(a_commit_free, cmd.commit |-> sts.out_free, "commit over pending result")

endmodule

### sim/tb_tlb_page_table_translate.sv
// ----------------------------------------------------------------------------
// tb_tlb_page_table_translate
// Self-checking bench for the TLB / demand-paging translator. A scoreboard
// class keeps its own TLB, page table and frame allocator. It predicts
// frame, physical address, outcome and both counts for every accepted
// address and checks the results in order. Stimulus is a directed opening
// (address extremes, TLB fill and FIFO eviction, page table hits), then
// random addresses drawn mostly from recently used and already mapped pages.
// Both sides idle at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_tlb_page_table_translate
    import tlbpt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_PHASE  = 410;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 10;
    localparam int RECENT_DEPTH  = 20;

    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic [ADDR_W-1:0]  phys;
        t_outcome           outcome;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] faults;
    } t_xlate;

    class xlate_checker;
        logic [PAGE_BITS-1:0] tlb_page  [TLB_ENTRIES];
        logic [FRAME_W-1:0]   tlb_frame [TLB_ENTRIES];
        bit                   tlb_valid [TLB_ENTRIES];
        int                   tlb_oldest;
        bit                   page_valid [NUM_PAGES];
        logic [FRAME_W-1:0]   page_frame [NUM_PAGES];
        logic [NEXT_W-1:0]    next_frame;
        logic [COUNT_W-1:0]   hits_seen;
        logic [COUNT_W-1:0]   faults_seen;
        t_xlate               expected_xlates [$];
        int                   mismatches;

        function new();
            foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
            foreach (page_valid[i]) page_valid[i] = 1'b0;
            tlb_oldest  = 0;
            next_frame  = '0;
            hits_seen   = '0;
            faults_seen = '0;
            mismatches  = 0;
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) $display("%0t: %s", $time, what);
        endfunction

        function void tlb_fill_slot(logic [PAGE_BITS-1:0] page, logic [FRAME_W-1:0] frame);
            tlb_page[tlb_oldest]  = page;
            tlb_frame[tlb_oldest] = frame;
            tlb_valid[tlb_oldest] = 1'b1;
            tlb_oldest = (tlb_oldest + 1) % TLB_ENTRIES;
        endfunction

        function void note_address(logic [ADDR_W-1:0] va);
            logic [PAGE_BITS-1:0]   page;
            logic [OFFSET_BITS-1:0] offset;
            bit                     hit;
            t_xlate                 x;
            page   = va[OFFSET_BITS +: PAGE_BITS];
            offset = va[OFFSET_BITS-1:0];
            hit    = 1'b0;
            x.frame = '0;
            foreach (tlb_valid[i]) begin
                if (!hit && tlb_valid[i] && tlb_page[i] == page) begin
                    hit     = 1'b1;
                    x.frame = tlb_frame[i];
                end
            end
            if (hit) begin
                x.outcome = OUT_TLB_HIT;
                if (hits_seen != '1) hits_seen++;
            end else if (page_valid[page]) begin
                x.outcome = OUT_PT_HIT;
                x.frame   = page_frame[page];
                tlb_fill_slot(page, x.frame);
            end else begin
                x.outcome = OUT_FAULT;
                if (faults_seen != '1) faults_seen++;
                x.frame = next_frame[FRAME_W-1:0];
                page_valid[page] = 1'b1;
                page_frame[page] = x.frame;
                next_frame++;
                tlb_fill_slot(page, x.frame);
            end
            x.phys   = ADDR_W'({x.frame, offset});
            x.hits   = hits_seen;
            x.faults = faults_seen;
            expected_xlates.push_back(x);
        endfunction

        function void check_result(logic [FRAME_W-1:0] frame, logic [ADDR_W-1:0] phys,
                                   logic [1:0] outcome, logic [COUNT_W-1:0] hits,
                                   logic [COUNT_W-1:0] faults);
            t_xlate e;
            if (expected_xlates.size() == 0) begin
                flag($sformatf("result with no translation outstanding: frame %0h pa %0h",
                               frame, phys));
            end else begin
                e = expected_xlates.pop_front();
                if (frame !== e.frame || phys !== e.phys || outcome !== e.outcome ||
                    hits !== e.hits || faults !== e.faults) begin
                    flag($sformatf({"mismatch: frame %0h/%0h pa %0h/%0h outcome %0d/%0d ",
                                    "hits %0d/%0d faults %0d/%0d (exp/got)"},
                                   e.frame, frame, e.phys, phys, e.outcome, outcome,
                                   e.hits, hits, e.faults, faults));
                end
            end
        endfunction
    endclass

    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_in_valid        = 1'b0;
    logic [ADDR_W-1:0]  i_virtual_address = '0;
    logic               i_out_stall       = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [FRAME_W-1:0] o_frame;
    logic [ADDR_W-1:0]  o_physical_address;
    logic [1:0]         o_outcome;
    logic [COUNT_W-1:0] o_tlb_hit_count;
    logic [COUNT_W-1:0] o_fault_count;

    xlate_checker         sb = new();
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    bit                   hold_off_req  = 1'b0;
    int                   hold_left     = 0;
    int                   cycles        = 0;
    logic [PAGE_BITS-1:0] recent_pages [$];
    logic [PAGE_BITS-1:0] mapped_pages [$];

    tlb_page_table_translate dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_virtual_address  (i_virtual_address),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_frame            (o_frame),
        .o_physical_address (o_physical_address),
        .o_outcome          (o_outcome),
        .o_tlb_hit_count    (o_tlb_hit_count),
        .o_fault_count      (o_fault_count)
    );

    always #2 i_clk = ~i_clk;

    // valid stays high between back-to-back transfers; only gaps lower it
    task automatic send_addr(input logic [ADDR_W-1:0] va);
        logic [PAGE_BITS-1:0] page;
        page = va[OFFSET_BITS +: PAGE_BITS];
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_virtual_address <= va;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!sb.page_valid[page]) mapped_pages.push_back(page);
        recent_pages.push_back(page);
        if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
        sb.note_address(va);
    endtask

    task automatic send_random(input int count);
        int                   pick;
        logic [PAGE_BITS-1:0] page;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 55 && recent_pages.size() > 0)
                page = recent_pages[$urandom_range(recent_pages.size() - 1)];
            else if (pick < 80 && mapped_pages.size() > 0)
                page = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
            else
                page = PAGE_BITS'($urandom);
            send_addr({page, OFFSET_BITS'($urandom)});
        end
    endtask

    // receiver: check the transfer at this edge, then pick the next stall
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_result(o_frame, o_physical_address, o_outcome,
                                o_tlb_hit_count, o_fault_count);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 17;
        recv_idle_pct = 73;
        // extremes of the address, then fill the TLB and push out its oldest entries
        send_addr(16'h0000);
        send_addr(16'h00FF);
        send_addr(16'hFFFF);
        send_addr(16'hFF00);
        for (int p = 1; p <= 16; p++) send_addr({8'(p), 8'(p) ^ 8'h5A});
        send_addr(16'h00AA);
        send_addr(16'hFF55);
        send_addr(16'h0F0F);
        send_random(RANDOM_PHASE);

        send_idle_pct = 73;
        recv_idle_pct = 17;
        send_random(RANDOM_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        send_random(RANDOM_PHASE);
        i_in_valid <= 1'b0;

        while (sb.expected_xlates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_xlates.size() != 0)
            sb.flag($sformatf("%0d translations never returned", sb.expected_xlates.size()));
        if (sb.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tlbpt_pkg.sv
rtl/tlbpt_ram.sv
rtl/tlbpt_ctrl.sv
rtl/tlbpt_dp.sv
rtl/tlb_page_table_translate.sv
sim/tb_tlb_page_table_translate.sv
